// ===== rtl/core/lkv_pkg.sv =====
// Shared widths, operation codes and cell types for the LRU key-value cache.
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic shift_down_all;
        logic shift_down_to_hit;
        logic shift_up_from_hit;
    } ctl_t;

endpackage

// ===== rtl/core/lkv_cell.sv =====
// One recency-ordered cell of the LRU cache: holds a key-value pair and shifts with neighbors.
module lkv_cell
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  logic [KEY_W-1:0] op_key,
    input  entry_t           prev_entry,
    input  entry_t           next_entry,
    input  logic             seen_in,
    output logic             seen_out,
    output logic             match,
    output entry_t           entry
);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             load_prev;
    logic             load_next;

    assign match    = valid_reg && (key_reg == op_key);
    assign seen_out = seen_in | match;

    // Shift toward the tail (every cell, or up to the hit), or pull up from the tail past it.
    assign load_prev = ctl.shift_down_all | (ctl.shift_down_to_hit & ~seen_in);
    assign load_next = ctl.shift_up_from_hit & (seen_in | match);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (load_prev)
        begin
            valid_next = prev_entry.valid;
            key_next   = prev_entry.key;
            value_next = prev_entry.value;
        end
        else if (load_next)
        begin
            valid_next = next_entry.valid;
            key_next   = next_entry.key;
            value_next = next_entry.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry = '{valid: valid_reg, key: key_reg, value: value_reg};

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: operation register, cell chain and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in      | receive   | in_valid / in_stall   | mode, key, value_in
//  out     | send      | out_valid / out_stall | hit, value_out
//
// Each accepted word waits in the operation register and executes against the
// cell chain once the result register can take it, landing in the result register
// at the edge that ends that cycle. The chain executes one operation per cycle, so
// back-to-back words sustain one word per cycle while the result is not stalled.
// Reset empties the cache (all cell valid bits clear) and both word registers.
// A stalled result holds the operation register; in_stall rises while it is full and cannot execute.
//
// The cells are kept in recency order: cell 0 is most recent and valid cells
// are packed at the head. A search or insert hit moves its word to the head;
// a new insert shifts every cell one step toward the tail and drops the tail
// (the LRU victim when full); a remove pulls cells behind the hit one step forward.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]  value_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [VAL_W-1:0]  value_out
);

    // Operation register
    logic              op_valid_reg;
    logic [MODE_W-1:0] op_mode_reg;
    logic [KEY_W-1:0]  op_key_reg;
    logic [VAL_W-1:0]  op_value_reg;

    // Result register
    logic              out_valid_reg;
    logic              hit_reg;
    logic [VAL_W-1:0]  value_out_reg;
    logic              hit_next;
    logic [VAL_W-1:0]  value_out_next;

    logic              fire;
    logic              accept;
    logic              is_search;
    logic              is_insert;
    logic              is_remove;
    logic              any_hit;
    logic [VAL_W-1:0]  match_value;
    ctl_t              ctl;
    entry_t            front_entry;
    entry_t            empty_entry;

    entry_t            cell_entry [CAPACITY];
    entry_t            down_bus   [CAPACITY];
    entry_t            up_bus     [CAPACITY];
    logic              seen       [CAPACITY+1];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] valid_vec;

    // Execute when an operation waits and the result register frees up this cycle.
    assign fire     = op_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = op_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    assign is_search = (op_mode_reg == MODE_SEARCH);
    assign is_insert = (op_mode_reg == MODE_INSERT);
    assign is_remove = (op_mode_reg == MODE_REMOVE);

    assign seen[0] = 1'b0;
    assign any_hit = seen[CAPACITY];

    always_comb
    begin
        match_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
                match_value = match_value | cell_entry[i].value;
        end
    end

    // Head word: the hit moves to the front keeping its value, a miss brings the new pair.
    assign front_entry = '{valid: 1'b1, key: op_key_reg,
                           value: any_hit ? match_value : op_value_reg};
    assign empty_entry = '{valid: 1'b0, key: '0, value: '0};

    assign ctl.shift_down_all    = fire && is_insert && !any_hit;
    assign ctl.shift_down_to_hit = fire && (is_search || is_insert) && any_hit;
    assign ctl.shift_up_from_hit = fire && is_remove && any_hit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign down_bus[g] = front_entry;
            end
            else
            begin : g_body
                assign down_bus[g] = cell_entry[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign up_bus[g] = empty_entry;
            end
            else
            begin : g_inner
                assign up_bus[g] = cell_entry[g+1];
            end

            lkv_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .op_key     (op_key_reg),
                .prev_entry (down_bus[g]),
                .next_entry (up_bus[g]),
                .seen_in    (seen[g]),
                .seen_out   (seen[g+1]),
                .match      (match_vec[g]),
                .entry      (cell_entry[g])
            );

            assign valid_vec[g] = cell_entry[g].valid;
        end
    endgenerate

    // Value goes out only on a search hit; an unused mode reports a miss.
    always_comb
    begin
        hit_next       = any_hit && (is_search || is_insert || is_remove);
        value_out_next = (is_search && any_hit) ? match_value : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                op_valid_reg <= 1'b1;
            else if (fire)
                op_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg  <= mode;
            op_key_reg   <= key;
            op_value_reg <= value_in;
        end
        if (fire)
        begin
            hit_reg       <= hit_next;
            value_out_reg <= value_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign value_out = value_out_reg;

    // Valid cells stay packed at the head of the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
        else $error("valid cells not packed at head");

    // The pending operation's key matches at most one valid cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg |-> $onehot0(match_vec))
        else $error("key present in more than one cell");

    // A remove that hits frees exactly one cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_remove && any_hit) |=>
        ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
        else $error("remove hit did not free one cell");

    // A nonzero value only comes with a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (value_out_reg != '0)) |-> hit_reg)
        else $error("value reported without hit");

endmodule
